FILE: sv/llad_pkg.sv
// ============================================================================
// llad_pkg: shared types and codes for the least-loaded affinity dispatcher
// Holds the transfer payload structs, the slot table entry layout, the
// configuration register indexes and the operation and strategy codes.
// ============================================================================
`default_nettype none

package llad_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT  = 1'd1;

  // Operation codes carried by an input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ASSIGN = 1'b1;

  // Strategy codes. The unused code behaves as least loaded.
  localparam logic [1:0] MODE_ROUND_ROBIN = 2'd0;
  localparam logic [1:0] MODE_LEAST       = 2'd1;
  localparam logic [1:0] MODE_SPECIALIST  = 2'd2;

  localparam logic [15:0] LOAD_MAX = 16'hFFFF;

  typedef struct packed {
    logic        operation;
    logic [3:0]  slot_index;
    logic [15:0] worker_id;
    logic [15:0] initial_load;
    logic [3:0]  category_mask;
    logic [1:0]  task_category;
  } in_item_t;

  typedef struct packed {
    logic        assigned;
    logic [15:0] chosen_id;
    logic [3:0]  chosen_slot;
  } out_item_t;

  // One worker slot as it is stored in the table memory.
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] load;
    logic [3:0]  mask;
  } slot_entry_t;

  // Status handed from the scan unit to the sequencer.
  typedef struct packed {
    logic        have_cat;
    logic [15:0] all_id;
    logic [15:0] cat_id;
  } scan_status_t;

endpackage

`default_nettype wire

FILE: sv/llad_table.sv
// ============================================================================
// llad_table: worker slot table
// Synchronous memory with one write port and one registered read port,
// holding id, load count and category mask for each worker slot.
// ============================================================================
`default_nettype none

module llad_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire llad_pkg::slot_entry_t wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output llad_pkg::slot_entry_t      rd_data
);

  llad_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/llad_scan.sv
// ============================================================================
// llad_scan: least-loaded tracker
// Takes one slot per cycle and keeps the best slot overall and the best
// slot whose category mask holds the task category.
// ============================================================================
`default_nettype none

module llad_scan #(
  parameter int AW = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clear,
  input  wire logic                  sample,
  input  wire logic [AW-1:0]         slot,
  input  wire llad_pkg::slot_entry_t entry,
  input  wire logic [1:0]            category,
  output llad_pkg::scan_status_t     status,
  output logic [AW-1:0]              all_slot,
  output logic [AW-1:0]              cat_slot
);

  logic        have_all;
  logic        have_cat;
  logic [15:0] all_load;
  logic [15:0] all_id;
  logic [15:0] cat_load;
  logic [15:0] cat_id;
  logic        beats_all;
  logic        beats_cat;
  logic        in_cat;

  // Lower load wins; on equal load the lower id wins. Slots arrive in
  // ascending order, so a strict compare leaves ties with the lower slot.
  assign beats_all = !have_all || (entry.load < all_load) ||
                     ((entry.load == all_load) && (entry.id < all_id));
  assign beats_cat = !have_cat || (entry.load < cat_load) ||
                     ((entry.load == cat_load) && (entry.id < cat_id));
  assign in_cat    = entry.mask[category];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      have_all <= 1'b0;
      have_cat <= 1'b0;
    end else if (sample) begin
      if (beats_all) begin
        have_all <= 1'b1;
        all_load <= entry.load;
        all_id   <= entry.id;
        all_slot <= slot;
      end
      if (in_cat && beats_cat) begin
        have_cat <= 1'b1;
        cat_load <= entry.load;
        cat_id   <= entry.id;
        cat_slot <= slot;
      end
    end
  end

  assign status = {have_cat, all_id, cat_id};

endmodule

`default_nettype wire

FILE: sv/least_loaded_affinity_dispatcher_unit.sv
// ============================================================================
// least_loaded_affinity_dispatcher_unit: task dispatcher over worker slots
// Keeps a table of worker slots and picks a worker for each task by round
// robin, least load, or least load among category specialists.
// ============================================================================
//
//   Port group     Dir   Handshake             Carries
//   in_*           in    in_valid / in_stall   llad_pkg::in_item_t
//   out_*          out   out_valid / out_stall llad_pkg::out_item_t
//   cfg_*          in    cfg_valid / cfg_ready register index and data
//
// A load transfer, or an assign with no workers, goes from idle straight to the
// done state. An assign under a least-loaded strategy makes one table read per
// slot to find the winner, then a second pass of reads to find the first slot
// holding the winning id and bump its load, all through the single read port of
// the table. Round robin first brings the rotate pointer back below the worker
// count, one subtraction at a time, then reads the picked slot and searches for
// the first slot holding its id to bump its load.
// Reset is synchronous and clears the strategy, worker count, rotate pointer
// and all handshake state; the table itself holds no reset value.
// The result sits in an output register, so a new item is taken while a
// stalled result still waits; a finished item waits for that register.
//
`default_nettype none

module least_loaded_affinity_dispatcher_unit #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire llad_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output llad_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [llad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [llad_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Slot address width and the width of a count that can hold the depth.
  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WRAP  = 6'b000010,
    S_RD    = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MATCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0] mode;
  logic [4:0] wcount;

  // Working registers of one item.
  logic [AW-1:0]       rotate_ptr;
  logic [CW-1:0]       n_act;
  logic [1:0]          cat;
  logic [CW-1:0]       iss;
  logic                pend;
  logic [AW-1:0]       pend_slot;
  logic [AW-1:0]       pick_slot;
  logic [15:0]         pick_id;
  llad_pkg::out_item_t res;

  // Table and scan unit connections.
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  llad_pkg::slot_entry_t  mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  llad_pkg::slot_entry_t  mem_rd_data;
  llad_pkg::scan_status_t scan_st;
  logic [AW-1:0]          scan_all_slot;
  logic [AW-1:0]          scan_cat_slot;

  logic          in_fire;
  logic [CW-1:0] n_calc;
  logic          slot_ok;
  logic          more_to_issue;
  logic          match_hit;
  logic          ptr_wraps;
  logic [CW-1:0] ptr_inc;
  logic          use_cat;

  // Only one item is in flight; the input side opens whenever the
  // sequencer is idle, even while the output register is still full.
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // A worker count above the table depth acts as the full table.
  assign n_calc  = (int'(wcount) > MAX_WORKERS) ? CW'(MAX_WORKERS) : CW'(wcount);
  assign slot_ok = (int'(in_data.slot_index) < MAX_WORKERS);

  assign more_to_issue = (iss < n_act);
  assign match_hit     = (state == S_MATCH) && pend && (mem_rd_data.id == pick_id);
  assign ptr_wraps     = (CW'(rotate_ptr) >= n_act);
  assign ptr_inc       = CW'(rotate_ptr) + CW'(1);
  assign use_cat       = (mode == llad_pkg::MODE_SPECIALIST) && scan_st.have_cat;

  // Table port steering. Loads write in the cycle of their transfer; the
  // load bump writes back the entry whose read data is on hand, so no read
  // of that entry is ever outstanding at the same time.
  always_comb begin
    mem_wr_en        = 1'b0;
    mem_wr_addr      = AW'(in_data.slot_index);
    mem_wr_data.id   = in_data.worker_id;
    mem_wr_data.load = in_data.initial_load;
    mem_wr_data.mask = in_data.category_mask;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = iss[AW-1:0];
    unique case (state)
      S_IDLE: begin
        mem_wr_en = in_fire && (in_data.operation == llad_pkg::OP_LOAD) && slot_ok;
      end
      S_WRAP: begin
        mem_rd_en   = !ptr_wraps;
        mem_rd_addr = rotate_ptr;
      end
      S_SCAN: begin
        mem_rd_en = more_to_issue;
      end
      S_MATCH: begin
        mem_rd_en        = more_to_issue && !match_hit;
        mem_wr_en        = match_hit;
        mem_wr_addr      = pend_slot;
        mem_wr_data      = mem_rd_data;
        mem_wr_data.load = (mem_rd_data.load == llad_pkg::LOAD_MAX) ?
                           mem_rd_data.load : mem_rd_data.load + 16'd1;
      end
      S_RD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  llad_table #(
    .DEPTH (MAX_WORKERS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  llad_scan #(
    .AW (AW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (in_fire),
    .sample   ((state == S_SCAN) && pend),
    .slot     (pend_slot),
    .entry    (mem_rd_data),
    .category (cat),
    .status   (scan_st),
    .all_slot (scan_all_slot),
    .cat_slot (scan_cat_slot)
  );

  // The user must send configuration writes only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= llad_pkg::MODE_ROUND_ROBIN;
      wcount <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        llad_pkg::CFG_STRATEGY_MODE: mode   <= cfg_data[1:0];
        llad_pkg::CFG_WORKER_COUNT:  wcount <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer. In both scan states one read is issued per cycle and its data comes
  // back from the registered read port in the next cycle, tracked by pend and pend_slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rotate_ptr <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // In S_DONE the output register either takes the new result or still
      // holds a stalled one, so it is valid after the edge either way.
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cat   <= in_data.task_category;
            n_act <= n_calc;
            iss   <= '0;
            pend  <= 1'b0;
            res   <= '0;
            if (in_data.operation == llad_pkg::OP_LOAD || n_calc == '0) begin
              state <= S_DONE;
            end else if (mode == llad_pkg::MODE_ROUND_ROBIN) begin
              state <= S_WRAP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_WRAP: begin
          // Reduce the pointer below the worker count one subtraction at a
          // time, then read the picked slot and advance the pointer.
          if (ptr_wraps) begin
            rotate_ptr <= rotate_ptr - AW'(n_act);
          end else begin
            pick_slot  <= rotate_ptr;
            rotate_ptr <= (ptr_inc == n_act) ? '0 : AW'(ptr_inc);
            state      <= S_RD;
          end
        end
        S_RD: begin
          pick_id <= mem_rd_data.id;
          iss     <= '0;
          pend    <= 1'b0;
          state   <= S_MATCH;
        end
        S_SCAN: begin
          if (more_to_issue) begin
            iss       <= iss + CW'(1);
            pend      <= 1'b1;
            pend_slot <= iss[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (!more_to_issue && !pend) begin
            pick_slot <= use_cat ? scan_cat_slot : scan_all_slot;
            pick_id   <= use_cat ? scan_st.cat_id : scan_st.all_id;
            iss       <= '0;
            state     <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (more_to_issue && !match_hit) begin
            iss       <= iss + CW'(1);
            pend      <= 1'b1;
            pend_slot <= iss[AW-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (match_hit || (!more_to_issue && !pend)) begin
            res.assigned    <= 1'b1;
            res.chosen_id   <= pick_id;
            res.chosen_slot <= 4'(pick_slot);
            state           <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/llad_checker.sv
// ============================================================================
// llad_checker: port-level checks for the dispatcher
// Watches the transfer ports of the top level over time.
// ============================================================================
`default_nettype none

module llad_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire llad_pkg::out_item_t out_data
);

  // A stalled result must hold until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result without an assignment carries zero id and slot.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.assigned |->
      (out_data.chosen_id == 16'd0) && (out_data.chosen_slot == 4'd0))
    else $error("unassigned result carries nonzero fields");

  // One item at a time: the input closes right after a transfer.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open in the cycle after a transfer");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind least_loaded_affinity_dispatcher_unit llad_checker u_llad_checker (.*);

`default_nettype wire
